/* hw/rtl/pte_pkg.sv */
// Package for the pixel ToT-to-energy calibration block.
// Holds geometry constants, result codes and shared pipeline types.
// No dependencies; the files that use it refer to it by scoped names.
package pte_pkg;

  // Sensor geometry and coefficient memory
  localparam int COLUMNS = 256;
  localparam int ROWS    = 256;
  localparam int DEPTH   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Operation codes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // Status codes
  localparam logic [1:0] ST_ROOT  = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  // 0.1 keV in unsigned Q16.16, rounded to nearest
  localparam logic [31:0] MIN_ENERGY = 32'd6554;
  localparam logic [31:0] MAX_ENERGY = 32'hFFFF_FFFF;

  // Pipeline depths of the iterative units
  localparam int SQRT_STEPS = 64;
  localparam int DIV_STEPS  = 32;

  // Per-pixel coefficients, signed Q15.16
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] t;
  } coef_t;

  // Control carried with each beat down the pipeline
  typedef struct packed {
    logic valid;  // beat will produce a result
    logic fb;     // no real solution: return the minimum energy
  } meta_t;

  // Operands the back end needs after the square root
  typedef struct packed {
    logic signed [63:0] bq;     // B in signed Q32
    logic               a_neg;  // sign of a
    logic [31:0]        am;     // magnitude of a
  } side_t;

endpackage

/* hw/rtl/pte_if.sv */
// Valid/ready channel interfaces for the calibration block.
// Input channel carries hits and coefficient loads, output carries energies.
// Depends on nothing.
interface pte_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         pixel_column;
  logic [7:0]         pixel_row;
  logic [9:0]         tot_ticks;
  logic signed [31:0] coef_slope;
  logic signed [31:0] coef_offset;
  logic signed [31:0] coef_curvature;
  logic signed [31:0] coef_threshold;

  modport source (
    output valid, operation, pixel_column, pixel_row, tot_ticks,
           coef_slope, coef_offset, coef_curvature, coef_threshold,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_column, pixel_row, tot_ticks,
           coef_slope, coef_offset, coef_curvature, coef_threshold,
    output ready
  );
endinterface

interface pte_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] energy_kev;
  logic [1:0]  status;

  modport source (output valid, energy_kev, status, input ready);
  modport sink   (input valid, energy_kev, status, output ready);
endinterface

/* hw/rtl/pte_coef_mem.sv */
// Coefficient memory: one 128-bit word (a, b, c, t) per pixel.
// Loads write on the accepting edge, converts read through a registered port.
// Depends on pte_pkg.
module pte_coef_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               accept,
  input  logic               operation,
  input  logic [7:0]         pixel_column,
  input  logic [7:0]         pixel_row,
  input  logic [9:0]         tot_ticks,
  input  pte_pkg::coef_t     wr_coef,
  output pte_pkg::meta_t     meta,
  output pte_pkg::coef_t     coef,
  output logic [9:0]         tot
);

  pte_pkg::coef_t mem [pte_pkg::DEPTH];

  logic                      in_range;
  logic [pte_pkg::ADDR_W-1:0] addr;
  logic                      is_load;
  logic                      is_conv;
  pte_pkg::meta_t            meta_r;
  pte_pkg::meta_t            meta_nxt;
  pte_pkg::coef_t            coef_r;
  logic [9:0]                tot_r;

  // Address decode: row-major, out-of-range pixels never touch memory
  always_comb begin
    in_range = (32'(pixel_column) < 32'(pte_pkg::COLUMNS)) &&
               (32'(pixel_row) < 32'(pte_pkg::ROWS));
    addr     = pte_pkg::ADDR_W'(32'(pixel_row) * 32'(pte_pkg::COLUMNS) +
                                32'(pixel_column));
    is_load  = accept && (operation == pte_pkg::OP_LOAD);
    is_conv  = accept && (operation == pte_pkg::OP_CONVERT);
    meta_nxt.valid = is_conv;
    meta_nxt.fb    = !in_range;
  end

  // Write port
  always_ff @(posedge clk) begin
    if (is_load && in_range) begin
      mem[addr] <= wr_coef;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (is_conv && in_range) begin
      coef_r <= mem[addr];
    end
  end

  // Beat control and ToT ride alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_r <= '0;
    end else if (adv) begin
      meta_r <= meta_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tot_r <= tot_ticks;
    end
  end

  assign meta = meta_r;
  assign coef = coef_r;
  assign tot  = tot_r;

endmodule

/* hw/rtl/pte_disc.sv */
// Front arithmetic: forms B, C and the discriminant B*B - 4aC in six stages.
// The wide products B*B and a*C are split into 32x32 partials, each registered before summing.
// Depends on pte_pkg.
module pte_disc (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  pte_pkg::meta_t  meta_in,
  input  pte_pkg::coef_t  coef,
  input  logic [9:0]      tot,
  output pte_pkg::meta_t  meta,
  output logic [127:0]    disc,
  output pte_pkg::side_t  side
);

  // S1: first products
  pte_pkg::meta_t     m1_r;
  logic signed [63:0] at_r, bt_r;
  logic signed [42:0] tt_r;
  logic signed [31:0] a1_r, b1_r, c1_r;
  logic [9:0]         tot1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_r <= '0;
    else if (adv) m1_r <= meta_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      at_r   <= coef.a * coef.t;
      bt_r   <= coef.b * coef.t;
      tt_r   <= $signed({1'b0, tot}) * coef.t;
      a1_r   <= coef.a;
      b1_r   <= coef.b;
      c1_r   <= coef.c;
      tot1_r <= tot;
    end
  end

  // S2: B and C in signed Q32
  pte_pkg::meta_t     m2_r;
  logic signed [63:0] bq2_r, cq2_r;
  logic signed [31:0] a2_r;
  logic [63:0]        bq_nxt, cq_nxt;

  always_comb begin
    bq_nxt = 64'(-at_r) + {{16{b1_r[31]}}, b1_r, 16'b0} - {22'b0, tot1_r, 32'b0};
    cq_nxt = {{5{tt_r[42]}}, tt_r, 16'b0} - bt_r - {{16{c1_r[31]}}, c1_r, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2_r <= '0;
    else if (adv) m2_r <= m1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bq2_r <= bq_nxt;
      cq2_r <= cq_nxt;
      a2_r  <= a1_r;
    end
  end

  // S3: magnitudes and signs
  pte_pkg::meta_t     m3_r;
  logic [63:0]        bm3_r, cm3_r;
  logic [31:0]        am3_r;
  logic               acn3_r, az3_r, an3_r;
  logic signed [63:0] bq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m3_r <= '0;
    else if (adv) m3_r <= m2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bm3_r  <= bq2_r[63] ? 64'(-bq2_r) : 64'(bq2_r);
      cm3_r  <= cq2_r[63] ? 64'(-cq2_r) : 64'(cq2_r);
      am3_r  <= a2_r[31] ? 32'(-a2_r) : 32'(a2_r);
      acn3_r <= a2_r[31] ^ cq2_r[63];
      az3_r  <= (a2_r == 32'sd0);
      an3_r  <= a2_r[31];
      bq3_r  <= bq2_r;
    end
  end

  // S4: 32x32 partial products
  pte_pkg::meta_t     m4_r;
  logic [63:0]        bhh_r, bhl_r, bll_r, ach_r, acl_r;
  logic               acn4_r, az4_r;
  pte_pkg::side_t     s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m4_r <= '0;
    else if (adv) m4_r <= m3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bhh_r  <= bm3_r[63:32] * bm3_r[63:32];
      bhl_r  <= bm3_r[63:32] * bm3_r[31:0];
      bll_r  <= bm3_r[31:0] * bm3_r[31:0];
      ach_r  <= am3_r * cm3_r[63:32];
      acl_r  <= am3_r * cm3_r[31:0];
      acn4_r <= acn3_r;
      az4_r  <= az3_r;
      s4_r.bq    <= bq3_r;
      s4_r.a_neg <= an3_r;
      s4_r.am    <= am3_r;
    end
  end

  // S5: assemble B*B (Q64) and 4aC, i.e. a*C shifted by 18
  pte_pkg::meta_t m5_r;
  logic [127:0]   bsq_r, acs_r;
  logic           acn5_r, az5_r;
  pte_pkg::side_t s5_r;
  logic [95:0]    ac_sum;

  assign ac_sum = {ach_r, 32'b0} + {32'b0, acl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) m5_r <= '0;
    else if (adv) m5_r <= m4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bsq_r  <= {bhh_r, 64'b0} + {31'b0, bhl_r, 33'b0} + {64'b0, bll_r};
      acs_r  <= {14'b0, ac_sum, 18'b0};
      acn5_r <= acn4_r;
      az5_r  <= az4_r;
      s5_r   <= s4_r;
    end
  end

  // S6: discriminant; zero slope or negative discriminant falls back
  pte_pkg::meta_t m6_r;
  pte_pkg::meta_t m6_nxt;
  logic [127:0]   disc_nxt;
  logic [127:0]   disc_r;
  pte_pkg::side_t s6_r;

  always_comb begin
    disc_nxt     = acn5_r ? (bsq_r + acs_r) : (bsq_r - acs_r);
    m6_nxt.valid = m5_r.valid;
    m6_nxt.fb    = m5_r.fb || az5_r || disc_nxt[127];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m6_r <= '0;
    else if (adv) m6_r <= m6_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      disc_r <= disc_nxt;
      s6_r   <= s5_r;
    end
  end

  assign meta = m6_r;
  assign disc = disc_r;
  assign side = s6_r;

endmodule

/* hw/rtl/pte_sqrt.sv */
// Pipelined floor square root of the 128-bit discriminant.
// One result bit per stage, digit-recurrence on a 67-bit remainder.
// Depends on pte_pkg.
module pte_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  pte_pkg::meta_t  meta_in,
  input  logic [127:0]    rad_in,
  input  pte_pkg::side_t  side_in,
  output pte_pkg::meta_t  meta,
  output logic [63:0]     root,
  output pte_pkg::side_t  side
);

  localparam int N = pte_pkg::SQRT_STEPS;

  pte_pkg::meta_t meta_r [N];
  pte_pkg::side_t side_r [N];
  logic [127:0]   rad_r  [N];
  logic [66:0]    rem_r  [N];
  logic [63:0]    root_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    pte_pkg::meta_t m_i;
    pte_pkg::side_t s_i;
    logic [127:0]   rad_i;
    logic [66:0]    rem_i;
    logic [63:0]    root_i;
    logic [66:0]    rem_sh, trial, rem_nxt;
    logic           ge;

    if (k == 0) begin : g_first
      assign m_i    = meta_in;
      assign s_i    = side_in;
      assign rad_i  = rad_in;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign m_i    = meta_r[k-1];
      assign s_i    = side_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    // Bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh  = {rem_i[64:0], rad_i[127:126]};
      trial   = {1'b0, root_i, 2'b01};
      ge      = (rem_sh >= trial);
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) meta_r[k] <= '0;
      else if (adv) meta_r[k] <= m_i;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= s_i;
        rad_r[k]  <= {rad_i[125:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {root_i[62:0], ge};
      end
    end
  end

  assign meta = meta_r[N-1];
  assign root = root_r[N-1];
  assign side = side_r[N-1];

endmodule

/* hw/rtl/pte_div.sv */
// Back end: numerator -B + root, saturation check and a pipelined
// restoring divider by 2|a| giving a 32-bit Q16.16 quotient.
// Depends on pte_pkg.
module pte_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  pte_pkg::meta_t  meta_in,
  input  logic [63:0]     root,
  input  pte_pkg::side_t  side_in,
  output pte_pkg::meta_t  meta,
  output logic            neg,
  output logic            sat,
  output logic [31:0]     quot
);

  localparam int N = pte_pkg::DIV_STEPS;

  // D0: signed numerator
  pte_pkg::meta_t     m0_r;
  logic signed [65:0] num_r;
  logic               an0_r;
  logic [31:0]        am0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m0_r <= '0;
    else if (adv) m0_r <= meta_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= {2'b00, root} - {{2{side_in.bq[63]}}, side_in.bq};
      an0_r <= side_in.a_neg;
      am0_r <= side_in.am;
    end
  end

  // D1: magnitude, result sign and divisor
  pte_pkg::meta_t m1_r;
  logic [64:0]    mag1_r;
  logic           neg1_r;
  logic [32:0]    den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_r <= '0;
    else if (adv) m1_r <= m0_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r <= num_r[65] ? 65'(-num_r) : num_r[64:0];
      neg1_r <= num_r[65] ^ an0_r;
      den1_r <= {am0_r, 1'b0};
    end
  end

  // D2: quotient of 2^32 or more saturates; seed the remainder
  pte_pkg::meta_t meta_r [N+1];
  logic           neg_r  [N+1];
  logic           sat_r  [N+1];
  logic [32:0]    den_r  [N+1];
  logic [32:0]    rem_r  [N+1];
  logic [31:0]    lo_r   [N+1];
  logic [31:0]    q_r    [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) meta_r[0] <= '0;
    else if (adv) meta_r[0] <= m1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r[0] <= neg1_r;
      sat_r[0] <= (mag1_r >= {den1_r, 32'b0});
      den_r[0] <= den1_r;
      rem_r[0] <= mag1_r[64:32];
      lo_r[0]  <= mag1_r[31:0];
      q_r[0]   <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [33:0] rem_sh;
    logic        ge;
    logic [33:0] rem_sub;

    always_comb begin
      rem_sh  = {rem_r[k], lo_r[k][31]};
      ge      = (rem_sh >= {1'b0, den_r[k]});
      rem_sub = rem_sh - {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) meta_r[k+1] <= '0;
      else if (adv) meta_r[k+1] <= meta_r[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        neg_r[k+1] <= neg_r[k];
        sat_r[k+1] <= sat_r[k];
        den_r[k+1] <= den_r[k];
        rem_r[k+1] <= ge ? rem_sub[32:0] : rem_sh[32:0];
        lo_r[k+1]  <= {lo_r[k][30:0], 1'b0};
        q_r[k+1]   <= {q_r[k][30:0], ge};
      end
    end
  end

  assign meta = meta_r[N];
  assign neg  = neg_r[N];
  assign sat  = sat_r[N];
  assign quot = q_r[N];

endmodule

/* hw/rtl/pixel_tot_to_energy_calibration.sv */
// Pixel ToT-to-energy calibration: per-pixel quadratic root in fixed point.
// Pipeline: a convert beat passes the memory read register, 6 discriminant stages,
// 64 square-root stages, 3 + 32 divider stages and the output register.
// Throughput: one beat per cycle, loads and converts mixed; the pipeline
// advances whenever the output register is empty or being taken.
// Reset clears all beat-valid flags; the coefficient memory is not cleared.
module pixel_tot_to_energy_calibration (
  input  logic         clk,
  input  logic         rst_n,
  pte_in_if.sink       in_ch,
  pte_out_if.source    out_ch
);

  logic           adv;
  logic           accept;
  pte_pkg::coef_t wr_coef;

  pte_pkg::meta_t mem_meta, dsc_meta, sq_meta, dv_meta;
  pte_pkg::coef_t mem_coef;
  logic [9:0]     mem_tot;
  logic [127:0]   dsc_disc;
  pte_pkg::side_t dsc_side, sq_side;
  logic [63:0]    sq_root;
  logic           dv_neg, dv_sat;
  logic [31:0]    dv_quot;

  logic           out_valid_r;
  logic [31:0]    energy_r, energy_nxt;
  logic [1:0]     status_r, status_nxt;

  // Handshake: whole pipeline moves together with the output register
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign accept       = in_ch.valid && adv;

  assign wr_coef.a = in_ch.coef_slope;
  assign wr_coef.b = in_ch.coef_offset;
  assign wr_coef.c = in_ch.coef_curvature;
  assign wr_coef.t = in_ch.coef_threshold;

  pte_coef_mem u_mem (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .accept       (accept),
    .operation    (in_ch.operation),
    .pixel_column (in_ch.pixel_column),
    .pixel_row    (in_ch.pixel_row),
    .tot_ticks    (in_ch.tot_ticks),
    .wr_coef      (wr_coef),
    .meta         (mem_meta),
    .coef         (mem_coef),
    .tot          (mem_tot)
  );

  pte_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .meta_in (mem_meta),
    .coef    (mem_coef),
    .tot     (mem_tot),
    .meta    (dsc_meta),
    .disc    (dsc_disc),
    .side    (dsc_side)
  );

  pte_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .meta_in (dsc_meta),
    .rad_in  (dsc_disc),
    .side_in (dsc_side),
    .meta    (sq_meta),
    .root    (sq_root),
    .side    (sq_side)
  );

  pte_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .meta_in (sq_meta),
    .root    (sq_root),
    .side_in (sq_side),
    .meta    (dv_meta),
    .neg     (dv_neg),
    .sat     (dv_sat),
    .quot    (dv_quot)
  );

  // Final selection: fallback, clamp low, saturate high
  always_comb begin
    if (dv_meta.fb) begin
      energy_nxt = pte_pkg::MIN_ENERGY;
      status_nxt = pte_pkg::ST_NOSOL;
    end else if (dv_neg) begin
      energy_nxt = pte_pkg::MIN_ENERGY;
      status_nxt = pte_pkg::ST_CLAMP;
    end else if (dv_sat) begin
      energy_nxt = pte_pkg::MAX_ENERGY;
      status_nxt = pte_pkg::ST_ROOT;
    end else if (dv_quot < pte_pkg::MIN_ENERGY) begin
      energy_nxt = pte_pkg::MIN_ENERGY;
      status_nxt = pte_pkg::ST_CLAMP;
    end else begin
      energy_nxt = dv_quot;
      status_nxt = pte_pkg::ST_ROOT;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      energy_r <= energy_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.energy_kev = energy_r;
  assign out_ch.status     = status_r;

  // Any non-root status reports exactly the minimum energy
  a_fallback_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != pte_pkg::ST_ROOT) |-> energy_r == pte_pkg::MIN_ENERGY)
    else $error("fallback beat without minimum energy");

  // A found root is never below the minimum
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == pte_pkg::ST_ROOT) |-> energy_r >= pte_pkg::MIN_ENERGY)
    else $error("root beat below minimum energy");

  // A stall freezes the pipeline tail
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_meta))
    else $error("pipeline moved during stall");

  // A convert beat reaches the memory read stage on the next edge
  a_conv_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == pte_pkg::OP_CONVERT) |=> mem_meta.valid)
    else $error("convert beat lost at memory stage");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for the pixel ToT-to-energy calibration block.
// Depends on pte_pkg, pte_if and the top level; drives loads and hits, checks energies.
module tb_top;

  typedef struct {
    logic        op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [9:0]  tot;
    logic [31:0] a, b, c, t;
    bit          known;
    logic [31:0] e;
    logic [1:0]  st;
  } hit_t;

  typedef struct {
    logic [31:0] e;
    logic [1:0]  st;
  } energy_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  pte_in_if  in_ch();
  pte_out_if out_ch();

  pixel_tot_to_energy_calibration uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  pte_pkg::coef_t coef_mem [int];
  int             loaded_pix [$];
  energy_t        energy_q [$];
  hit_t           directed [$];
  int             errors = 0;
  int             n_rcv = 0;
  int             idle_cnt = 0;
  bit             burst = 0;
  bit             pressure_done = 0;

  // Solve the calibration quadratic in exact fixed point
  function automatic energy_t solve_energy(pte_pkg::coef_t k, logic [9:0] tot_in);
    longint a, b, c, t, tot, bq, cq;
    logic signed [127:0] bq_w, a_w, cq_w, disc, num;
    logic [127:0] mag, den, q, sq;
    logic [63:0] r, cand;
    bit neg;
    energy_t res;
    a = longint'(k.a); b = longint'(k.b); c = longint'(k.c); t = longint'(k.t);
    tot = longint'(tot_in);
    bq = -(a * t) + b * 65536 - tot * 64'sd4294967296;
    cq = tot * t * 65536 - b * t - c * 65536;
    bq_w = 128'(bq); a_w = 128'(a); cq_w = 128'(cq);
    disc = bq_w * bq_w - ((a_w * cq_w) <<< 18);
    if (a == 0 || disc[127]) begin
      res.e = pte_pkg::MIN_ENERGY; res.st = pte_pkg::ST_NOSOL;
      return res;
    end
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= disc) r = cand;
    end
    num = -bq_w + $signed({64'd0, r});
    neg = num[127] ^ (a < 0);
    mag = num[127] ? -num : num;
    den = (a < 0) ? 128'(-a) * 2 : 128'(a) * 2;
    q = mag / den;
    if (neg || q < pte_pkg::MIN_ENERGY) begin
      res.e = pte_pkg::MIN_ENERGY; res.st = pte_pkg::ST_CLAMP;
    end else if (q > 128'(pte_pkg::MAX_ENERGY)) begin
      res.e = pte_pkg::MAX_ENERGY; res.st = pte_pkg::ST_ROOT;
    end else begin
      res.e = q[31:0]; res.st = pte_pkg::ST_ROOT;
    end
    return res;
  endfunction

  // Apply an accepted beat to the coefficient memory copy, queue its energy
  task automatic track_beat(hit_t h);
    int idx;
    energy_t x;
    idx = int'(h.row) * pte_pkg::COLUMNS + int'(h.col);
    if (h.op == pte_pkg::OP_LOAD) begin
      coef_mem[idx] = '{a: h.a, b: h.b, c: h.c, t: h.t};
      if (!(idx inside {loaded_pix})) loaded_pix = {loaded_pix, idx};
    end else begin
      x = solve_energy(coef_mem[idx], h.tot);
      if (h.known) begin
        x.e = h.e; x.st = h.st;
      end
      energy_q = {energy_q, x};
    end
  endtask

  function automatic int gap_len();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    int idx, kind;
    h = '{default: '0};
    h.tot = 10'($urandom_range(0, 1023));
    if (loaded_pix.size() == 0 || $urandom_range(0, 99) < 30) begin
      h.op = pte_pkg::OP_LOAD;
      if (loaded_pix.size() > 0 && $urandom_range(0, 1)) begin
        idx = loaded_pix[$urandom_range(0, loaded_pix.size() - 1)];
        h.col = 8'(idx % pte_pkg::COLUMNS); h.row = 8'(idx / pte_pkg::COLUMNS);
      end else begin
        h.col = 8'($urandom); h.row = 8'($urandom);
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // plausible detector calibration
        h.a = $urandom_range(1 << 12, 1 << 19);
        h.b = $urandom_range(0, 60 << 16) - (10 << 16);
        h.c = $urandom_range(0, 600 << 16) - (50 << 16);
        h.t = $urandom_range(0, 12 << 16) - (2 << 16);
      end else if (kind < 8) begin
        h.a = $urandom; h.b = $urandom; h.c = $urandom; h.t = $urandom;
      end else if (kind == 8) begin
        h.a = -$urandom_range(1, 1 << 18);
        h.b = $urandom; h.c = $urandom_range(0, 1 << 24); h.t = $urandom_range(0, 1 << 20);
      end else begin
        h.a = $urandom_range(0, 3);
        h.b = $urandom_range(0, 1 << 20); h.c = $urandom; h.t = $urandom_range(0, 1 << 18);
      end
    end else begin
      h.op = pte_pkg::OP_CONVERT;
      idx = loaded_pix[$urandom_range(0, loaded_pix.size() - 1)];
      h.col = 8'(idx % pte_pkg::COLUMNS); h.row = 8'(idx / pte_pkg::COLUMNS);
      h.a = $urandom; h.b = $urandom; h.c = $urandom; h.t = $urandom;
    end
    return h;
  endfunction

  function automatic hit_t row_of(logic op, int col, int row, int tot,
                                  logic [31:0] a, b, c, t,
                                  bit known = 1'b0, logic [31:0] e = '0,
                                  logic [1:0] st = '0);
    hit_t h;
    h.op = op; h.col = 8'(col); h.row = 8'(row); h.tot = 10'(tot);
    h.a = a; h.b = b; h.c = c; h.t = t;
    h.known = known; h.e = e; h.st = st;
    return h;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(hit_t h);
    directed = {directed, h};
  endfunction

  // Sender: one beat at a time, changed at the falling edge
  task automatic send_beat(hit_t h);
    int g;
    g = gap_len();
    repeat (g) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = h.op;
    in_ch.pixel_column = h.col;
    in_ch.pixel_row = h.row;
    in_ch.tot_ticks = h.tot;
    in_ch.coef_slope = h.a;
    in_ch.coef_offset = h.b;
    in_ch.coef_curvature = h.c;
    in_ch.coef_threshold = h.t;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
      @(negedge clk);
    end
    track_beat(h);
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.operation = pte_pkg::OP_CONVERT;
    in_ch.pixel_column = '0; in_ch.pixel_row = '0; in_ch.tot_ticks = '0;
    in_ch.coef_slope = '0; in_ch.coef_offset = '0;
    in_ch.coef_curvature = '0; in_ch.coef_threshold = '0;
    out_ch.ready = 1'b0;

    // directed corners: realistic pixel, zero slope, extremes, no root, clamp, saturation
    add_row(row_of(pte_pkg::OP_LOAD, 0, 0, 0, 32'h0001_8000, 32'h0014_0000, 32'h012C_0000,
                   32'h0003_0000));
    add_row(row_of(pte_pkg::OP_CONVERT, 0, 0, 0, '1, '1, '1, '1));
    add_row(row_of(pte_pkg::OP_CONVERT, 0, 0, 1023, 0, 0, 0, 0));
    add_row(row_of(pte_pkg::OP_CONVERT, 0, 0, 200, 0, 0, 0, 0));
    add_row(row_of(pte_pkg::OP_LOAD, 255, 255, 0, 0, 32'h0010_0000, 32'h0001_0000,
                   32'h0001_0000));
    add_row(row_of(pte_pkg::OP_CONVERT, 255, 255, 512, 0, 0, 0, 0, 1'b1,
                   pte_pkg::MIN_ENERGY, pte_pkg::ST_NOSOL));
    add_row(row_of(pte_pkg::OP_LOAD, 255, 0, 0, 32'h0001_0000, 0, 32'hFFFF_0000, 0));
    add_row(row_of(pte_pkg::OP_CONVERT, 255, 0, 0, 0, 0, 0, 0, 1'b1,
                   pte_pkg::MIN_ENERGY, pte_pkg::ST_NOSOL));
    add_row(row_of(pte_pkg::OP_LOAD, 0, 255, 0, 32'd1, 0, 0, 0));
    add_row(row_of(pte_pkg::OP_CONVERT, 0, 255, 0, 0, 0, 0, 0, 1'b1,
                   pte_pkg::MIN_ENERGY, pte_pkg::ST_CLAMP));
    add_row(row_of(pte_pkg::OP_CONVERT, 0, 255, 1023, 0, 0, 0, 0, 1'b1,
                   pte_pkg::MAX_ENERGY, pte_pkg::ST_ROOT));
    add_row(row_of(pte_pkg::OP_LOAD, 17, 200, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF));
    add_row(row_of(pte_pkg::OP_CONVERT, 17, 200, 1023, 0, 0, 0, 0));
    add_row(row_of(pte_pkg::OP_LOAD, 200, 17, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000));
    add_row(row_of(pte_pkg::OP_CONVERT, 200, 17, 0, 0, 0, 0, 0));
    add_row(row_of(pte_pkg::OP_CONVERT, 200, 17, 1023, 0, 0, 0, 0));
    add_row(row_of(pte_pkg::OP_LOAD, 0, 0, 1023, 32'hFFFF_8000, 32'h0005_0000, 32'h0000_0000,
                   32'h0001_0000));
    add_row(row_of(pte_pkg::OP_CONVERT, 0, 0, 300, 0, 0, 0, 0));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_beat(directed[i]);
    for (int i = 0; i < 1250; i++) begin
      if (i % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      send_beat(rand_hit());
    end
    in_ch.valid = 1'b0;

    while (energy_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver ready: random stalls plus one long hold-off to back up the pipeline
  initial begin : rcv_ready
    int hold;
    int r;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!pressure_done && n_rcv >= 500) begin
        pressure_done = 1;
        hold = 400;
      end else if (hold == 0 && !burst) begin
        r = $urandom_range(0, 99);
        if (r < 25) hold = $urandom_range(1, 3);
        else if (r < 28) hold = $urandom_range(10, 60);
      end
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        hold--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Result check against the oldest pending energy
  always @(posedge clk) begin
    energy_t x;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_rcv++;
      if (energy_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result e=%h st=%0d",
                                   out_ch.energy_kev, out_ch.status);
      end else begin
        x = energy_q.pop_front();
        if (out_ch.energy_kev !== x.e || out_ch.status !== x.st) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d exp e=%h st=%0d got e=%h st=%0d",
                     n_rcv, x.e, x.st, out_ch.energy_kev, out_ch.status);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= 3000) begin
      $display("Test completed with failures");
      $finish;
    end
  end
endmodule
